### sv/mkd_pkg.sv
// Shared types, constants and the letter lookup for the Morse key decoder.
`timescale 1ns / 1ps

package mkd_pkg;

   localparam int MAX_SYMBOLS = 8;
   localparam int SYM_CNT_W   = $clog2(MAX_SYMBOLS + 1);
   localparam int TIMER_W     = 16;
   localparam int CFG_W       = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int CODE_W      = 7;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_DOT_LIMIT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LETTER_GAP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WORD_GAP   = 2'd2;

   localparam logic [CFG_W-1:0] DOT_LIMIT_RESET  = 16'd300;
   localparam logic [CFG_W-1:0] LETTER_GAP_RESET = 16'd1000;
   localparam logic [CFG_W-1:0] WORD_GAP_RESET   = 16'd2000;

   localparam logic EVENT_LETTER = 1'b0;
   localparam logic EVENT_WORD   = 1'b1;

   localparam logic [CODE_W-1:0] UNKNOWN_CODE = 7'd63;
   localparam logic [CODE_W-1:0] NO_CODE      = 7'd0;

   // Events caused by one tick: an optional letter, then an optional word end.
   typedef struct packed {
      logic              letter_vld;
      logic [CODE_W-1:0] letter_code;
      logic              word_vld;
   } tick_events_type;

   // Index is the leading-one marker followed by the symbols, dash is one.
   function automatic logic [CODE_W-1:0] letter_lookup(input logic [4:0] idx);
      logic [CODE_W-1:0] code;
      case (idx)
         5'd2:    code = 7'd69;  // E
         5'd3:    code = 7'd84;  // T
         5'd4:    code = 7'd73;  // I
         5'd5:    code = 7'd65;  // A
         5'd6:    code = 7'd78;  // N
         5'd7:    code = 7'd77;  // M
         5'd8:    code = 7'd83;  // S
         5'd9:    code = 7'd85;  // U
         5'd10:   code = 7'd82;  // R
         5'd11:   code = 7'd87;  // W
         5'd12:   code = 7'd68;  // D
         5'd13:   code = 7'd75;  // K
         5'd14:   code = 7'd71;  // G
         5'd15:   code = 7'd79;  // O
         5'd16:   code = 7'd72;  // H
         5'd17:   code = 7'd86;  // V
         5'd18:   code = 7'd70;  // F
         5'd20:   code = 7'd76;  // L
         5'd22:   code = 7'd80;  // P
         5'd23:   code = 7'd74;  // J
         5'd24:   code = 7'd66;  // B
         5'd25:   code = 7'd88;  // X
         5'd26:   code = 7'd67;  // C
         5'd27:   code = 7'd89;  // Y
         5'd28:   code = 7'd90;  // Z
         5'd29:   code = 7'd81;  // Q
         default: code = UNKNOWN_CODE;
      endcase
      return code;
   endfunction

   function automatic logic [CODE_W-1:0] decode_letter(
      input logic [SYM_CNT_W-1:0]   count,
      input logic [MAX_SYMBOLS-1:0] bits,
      input logic                   overflow
   );
      logic [4:0] idx;
      logic [CODE_W-1:0] code;
      idx = 5'd0;
      if (overflow || count == '0 || count > SYM_CNT_W'(4)) begin
         code = UNKNOWN_CODE;
      end else begin
         idx  = (5'd1 << count[2:0]) + {1'b0, bits[3:0]};
         code = letter_lookup(idx);
      end
      return code;
   endfunction

endpackage

### sv/mkd_front.sv
// Front part: configuration registers, tick timing and classification into event records.
`timescale 1ns / 1ps

module mkd_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [mkd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mkd_pkg::CFG_W-1:0]       csr_wdata,
   input  logic                            tick_accept,
   input  logic                            key_level,
   output logic                            push_valid,
   output mkd_pkg::tick_events_type        push_events
);
   import mkd_pkg::*;

   logic [CFG_W-1:0]       dot_limit_ff, letter_gap_ff, word_gap_ff;
   logic                   key_held_ff, key_held_in;
   logic [TIMER_W-1:0]     press_ticks_ff, press_ticks_in;
   logic [TIMER_W-1:0]     idle_ticks_ff, idle_ticks_in;
   logic [MAX_SYMBOLS-1:0] symbol_bits_ff, symbol_bits_in;
   logic [SYM_CNT_W-1:0]   symbol_count_ff, symbol_count_in;
   logic                   symbol_overflow_ff, symbol_overflow_in;
   logic                   word_open_ff, word_open_in;
   logic [TIMER_W-1:0]     duration;
   logic                   dash;
   logic                   letter_fire, word_fire;
   logic [CODE_W-1:0]      code;

   always_comb begin
      key_held_in        = key_held_ff;
      press_ticks_in     = press_ticks_ff;
      idle_ticks_in      = idle_ticks_ff;
      symbol_bits_in     = symbol_bits_ff;
      symbol_count_in    = symbol_count_ff;
      symbol_overflow_in = symbol_overflow_ff;
      word_open_in       = word_open_ff;
      duration    = (press_ticks_ff == '1) ? press_ticks_ff : press_ticks_ff + 1'b1;
      dash        = (duration >= dot_limit_ff);
      letter_fire = 1'b0;
      word_fire   = 1'b0;
      code        = NO_CODE;

      if (key_level) begin
         if (!key_held_ff) begin
            key_held_in    = 1'b1;
            press_ticks_in = '0;
         end else if (press_ticks_ff != '1) begin
            press_ticks_in = press_ticks_ff + 1'b1;
         end
      end else if (key_held_ff) begin
         if (symbol_count_ff < SYM_CNT_W'(MAX_SYMBOLS)) begin
            symbol_bits_in  = {symbol_bits_ff[MAX_SYMBOLS-2:0], dash};
            symbol_count_in = symbol_count_ff + 1'b1;
         end else begin
            symbol_overflow_in = 1'b1;
         end
         key_held_in   = 1'b0;
         idle_ticks_in = '0;
      end else if (idle_ticks_ff != '1) begin
         idle_ticks_in = idle_ticks_ff + 1'b1;
      end

      if (!key_held_in && symbol_count_in != '0 && idle_ticks_in >= letter_gap_ff) begin
         letter_fire        = 1'b1;
         code               = decode_letter(symbol_count_in, symbol_bits_in,
                                            symbol_overflow_in);
         symbol_bits_in     = '0;
         symbol_count_in    = '0;
         symbol_overflow_in = 1'b0;
         word_open_in       = 1'b1;
      end

      if (!key_held_in && word_open_in && idle_ticks_in >= word_gap_ff) begin
         word_fire    = 1'b1;
         word_open_in = 1'b0;
      end
   end

   assign push_valid              = tick_accept && (letter_fire || word_fire);
   assign push_events.letter_vld  = letter_fire;
   assign push_events.letter_code = code;
   assign push_events.word_vld    = word_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_limit_ff       <= DOT_LIMIT_RESET;
         letter_gap_ff      <= LETTER_GAP_RESET;
         word_gap_ff        <= WORD_GAP_RESET;
         key_held_ff        <= 1'b0;
         press_ticks_ff     <= '0;
         idle_ticks_ff      <= '0;
         symbol_bits_ff     <= '0;
         symbol_count_ff    <= '0;
         symbol_overflow_ff <= 1'b0;
         word_open_ff       <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_DOT_LIMIT:  dot_limit_ff  <= csr_wdata;
               CSR_LETTER_GAP: letter_gap_ff <= csr_wdata;
               CSR_WORD_GAP:   word_gap_ff   <= csr_wdata;
               default: ;
            endcase
         end
         if (tick_accept) begin
            key_held_ff        <= key_held_in;
            press_ticks_ff     <= press_ticks_in;
            idle_ticks_ff      <= idle_ticks_in;
            symbol_bits_ff     <= symbol_bits_in;
            symbol_count_ff    <= symbol_count_in;
            symbol_overflow_ff <= symbol_overflow_in;
            word_open_ff       <= word_open_in;
         end
      end
   end

endmodule

### sv/mkd_queue.sv
// Short queue of per-tick event records between the front and back parts.
`timescale 1ns / 1ps

module mkd_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   input  mkd_pkg::tick_events_type push_events,
   input  logic                     pop,
   output logic                     full,
   output logic                     empty,
   output mkd_pkg::tick_events_type head_events
);
   import mkd_pkg::*;

   tick_events_type        entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign full        = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty       = (count_ff == '0);
   assign head_events = entries_ff[rd_ptr_ff];
   assign do_push     = push_valid && !full;
   assign do_pop      = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_events;
      end
   end

endmodule

### sv/mkd_back.sv
// Back part: turns queued event records into result items in an output register.
`timescale 1ns / 1ps

module mkd_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              empty,
   input  mkd_pkg::tick_events_type          head_events,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_event_kind,
   output logic [mkd_pkg::CODE_W-1:0]        rsp_letter_code,
   output logic                              rsp_last_of_tick
);
   import mkd_pkg::*;

   logic              valid_ff, valid_in;
   logic              kind_ff, kind_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic              last_ff, last_in;
   logic              pend_word_ff, pend_word_in;
   logic              slot_free;

   assign slot_free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in     = valid_ff;
      kind_in      = kind_ff;
      code_in      = code_ff;
      last_in      = last_ff;
      pend_word_in = pend_word_ff;
      pop          = 1'b0;
      if (slot_free) begin
         valid_in = 1'b0;
         if (pend_word_ff) begin
            valid_in     = 1'b1;
            kind_in      = EVENT_WORD;
            code_in      = NO_CODE;
            last_in      = 1'b1;
            pend_word_in = 1'b0;
         end else if (!empty) begin
            pop      = 1'b1;
            valid_in = 1'b1;
            if (head_events.letter_vld) begin
               kind_in      = EVENT_LETTER;
               code_in      = head_events.letter_code;
               last_in      = !head_events.word_vld;
               pend_word_in = head_events.word_vld;
            end else begin
               kind_in = EVENT_WORD;
               code_in = NO_CODE;
               last_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         pend_word_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         pend_word_ff <= pend_word_in;
      end
      kind_ff <= kind_in;
      code_ff <= code_in;
      last_ff <= last_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_event_kind   = kind_ff;
   assign rsp_letter_code  = code_ff;
   assign rsp_last_of_tick = last_ff;

endmodule

### sv/morse_key_decoder.sv
// Top level of the Morse key decoder.
`timescale 1ns / 1ps

// The decoder takes one key sample item per clock cycle while the result side
// keeps up. Each accepted sample is timed and classified combinationally and
// yields zero, one or two result items (a letter, a word end, or both); a
// four-entry event queue sits between the classifier and the output register,
// so a tick with two results sends the letter and then the word end, and
// req_stall rises only when that queue is full. Results pass through the queue
// and the output register. Configuration writes take effect on the next cycle.

module morse_key_decoder (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [mkd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mkd_pkg::CFG_W-1:0]       csr_wdata,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_key_level,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_event_kind,
   output logic [mkd_pkg::CODE_W-1:0]      rsp_letter_code,
   output logic                            rsp_last_of_tick
);
   import mkd_pkg::*;

   logic            tick_accept;
   logic            push_valid;
   tick_events_type push_events;
   tick_events_type head_events;
   logic            queue_full, queue_empty, pop;

   assign req_stall   = queue_full;
   assign tick_accept = req_valid && !req_stall;

   mkd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .tick_accept (tick_accept),
      .key_level   (req_key_level),
      .push_valid  (push_valid),
      .push_events (push_events)
   );

   mkd_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (push_valid),
      .push_events (push_events),
      .pop         (pop),
      .full        (queue_full),
      .empty       (queue_empty),
      .head_events (head_events)
   );

   mkd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .empty            (queue_empty),
      .head_events      (head_events),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_letter_code  (rsp_letter_code),
      .rsp_last_of_tick (rsp_last_of_tick)
   );

endmodule

### tb/tb_top.sv
// Self-checking testbench for the Morse key decoder with an in-bench tick predictor.
`timescale 1ns / 1ps

module tb_top;
   import mkd_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 200_000;
   localparam int unsigned DRAIN_CYCLES = 4;
   localparam int unsigned CODE_LEN_MAX = MAX_SYMBOLS;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam logic [8*32-1:0] MORSE_TREE = "??ETIANMSURWDKGOHVF?L?PJBXCYZQ??";

   typedef struct packed {
      logic              kind;
      logic [CODE_W-1:0] code;
      logic              last;
   } key_event_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_DOT_LIMIT;
   logic [CFG_W-1:0]     csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_key_level = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_event_kind;
   logic [CODE_W-1:0]    rsp_letter_code;
   logic                 rsp_last_of_tick;

   key_event_type pending_events[$];
   int unsigned fail_count = 0;
   int unsigned tick_count = 0;
   int unsigned held_off_cycles = 0;
   int unsigned letters_seen = 0;
   int unsigned unknown_seen = 0;
   int unsigned word_ends_seen = 0;
   int unsigned cycle_count = 0;
   int unsigned hold_request = 0;
   bit          sender_gaps = 1'b1;
   bit          receiver_gaps = 1'b1;

   logic [TIMER_W-1:0] thr_dot;
   logic [TIMER_W-1:0] thr_letter;
   logic [TIMER_W-1:0] thr_word;
   logic               key_down;
   logic [TIMER_W-1:0] hold_len;
   logic [TIMER_W-1:0] quiet_len;
   logic [7:0]         code_bits;
   logic [3:0]         code_len;
   logic               code_too_long;
   logic               word_started;

   morse_key_decoder u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_key_level    (req_key_level),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_letter_code  (rsp_letter_code),
      .rsp_last_of_tick (rsp_last_of_tick)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   function automatic void clear_decoder_state();
      thr_dot       = DOT_LIMIT_RESET;
      thr_letter    = LETTER_GAP_RESET;
      thr_word      = WORD_GAP_RESET;
      key_down      = 1'b0;
      hold_len      = '0;
      quiet_len     = '0;
      code_bits     = '0;
      code_len      = '0;
      code_too_long = 1'b0;
      word_started  = 1'b0;
   endfunction

   function automatic logic [CODE_W-1:0] letter_of_code();
      int unsigned idx;
      logic [7:0]  tree_char;
      if (code_too_long || code_len == 4'd0 || code_len > 4'd4) begin
         return UNKNOWN_CODE;
      end
      idx = (32'd1 << code_len) + {28'd0, code_bits[3:0]};
      tree_char = MORSE_TREE[8*(31-idx) +: 8];
      return tree_char[CODE_W-1:0];
   endfunction

   // Advances the decoder state by one key sample and queues the events it causes.
   function automatic void decode_tick(input logic level);
      key_event_type      ev;
      logic [TIMER_W-1:0] duration;
      int unsigned        queued;
      queued = pending_events.size();
      if (level) begin
         if (!key_down) begin
            key_down = 1'b1;
            hold_len = '0;
         end else if (hold_len != '1) begin
            hold_len = hold_len + 1'b1;
         end
      end else if (key_down) begin
         duration = (hold_len == '1) ? hold_len : hold_len + 1'b1;
         if (code_len < 4'(CODE_LEN_MAX)) begin
            code_bits = {code_bits[6:0], duration >= thr_dot};
            code_len  = code_len + 1'b1;
         end else begin
            code_too_long = 1'b1;
         end
         key_down  = 1'b0;
         quiet_len = '0;
      end else if (quiet_len != '1) begin
         quiet_len = quiet_len + 1'b1;
      end
      if (!key_down && code_len != 4'd0 && quiet_len >= thr_letter) begin
         ev.kind = EVENT_LETTER;
         ev.code = letter_of_code();
         ev.last = 1'b0;
         pending_events.push_back(ev);
         code_bits     = '0;
         code_len      = '0;
         code_too_long = 1'b0;
         word_started  = 1'b1;
      end
      if (!key_down && word_started && quiet_len >= thr_word) begin
         ev.kind = EVENT_WORD;
         ev.code = NO_CODE;
         ev.last = 1'b0;
         pending_events.push_back(ev);
         word_started = 1'b0;
      end
      if (pending_events.size() > queued) begin
         pending_events[pending_events.size()-1].last = 1'b1;
      end
   endfunction

   task automatic check_result();
      key_event_type want;
      if (pending_events.size() == 0) begin
         $error("unexpected item: event_kind %0d letter_code %0d last_of_tick %0d",
                rsp_event_kind, rsp_letter_code, rsp_last_of_tick);
         fail_count++;
      end else begin
         want = pending_events.pop_front();
         if (rsp_event_kind !== want.kind) begin
            $error("event_kind: expected %0d, actual %0d", want.kind, rsp_event_kind);
            fail_count++;
         end
         if (rsp_letter_code !== want.code) begin
            $error("letter_code: expected %0d, actual %0d", want.code, rsp_letter_code);
            fail_count++;
         end
         if (rsp_last_of_tick !== want.last) begin
            $error("last_of_tick: expected %0d, actual %0d", want.last, rsp_last_of_tick);
            fail_count++;
         end
         if (want.kind == EVENT_WORD) begin
            word_ends_seen++;
         end else begin
            letters_seen++;
            if (want.code == UNKNOWN_CODE) begin
               unknown_seen++;
            end
         end
      end
   endtask

   initial begin : result_checker
      int unsigned stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            check_result();
         end
         if (hold_request != 0) begin
            stall_left   = hold_request;
            hold_request = 0;
         end
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (receiver_gaps && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(0, 6);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_tick(input logic level);
      int unsigned gap;
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 7);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_key_level <= level;
      @(posedge clock);
      while (req_stall) begin
         held_off_cycles++;
         @(posedge clock);
      end
      decode_tick(level);
      tick_count++;
   endtask

   task automatic key_press(input int unsigned len);
      repeat (len) send_tick(1'b1);
   endtask

   task automatic key_idle(input int unsigned len);
      repeat (len) send_tick(1'b0);
   endtask

   function automatic int unsigned press_len(input logic dash);
      int unsigned lim;
      lim = int'(thr_dot);
      if (dash || lim < 2) begin
         return $urandom_range((lim == 0) ? 1 : lim, lim + 3);
      end
      return $urandom_range(1, lim - 1);
   endfunction

   function automatic int unsigned symbol_gap();
      return $urandom_range(1, (thr_letter == '0) ? 1 : int'(thr_letter));
   endfunction

   // Keys a code of len symbols, first symbol in the highest used bit, one is a dash.
   task automatic key_letter(input int unsigned len, input logic [15:0] pattern,
                             input int unsigned gap_after);
      int unsigned i;
      for (i = 0; i < len; i++) begin
         key_press(press_len(pattern[len-1-i]));
         key_idle((i == len - 1) ? gap_after : symbol_gap());
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_timing(input logic [CFG_W-1:0] dot, input logic [CFG_W-1:0] letter,
                              input logic [CFG_W-1:0] word);
      csr_we    <= 1'b1;
      csr_index <= CSR_DOT_LIMIT;
      csr_wdata <= dot;
      @(posedge clock);
      csr_index <= CSR_LETTER_GAP;
      csr_wdata <= letter;
      @(posedge clock);
      csr_index <= CSR_WORD_GAP;
      csr_wdata <= word;
      @(posedge clock);
      csr_index <= CSR_SPARE;
      csr_wdata <= CFG_W'($urandom());
      @(posedge clock);
      csr_we     <= 1'b0;
      thr_dot    = dot;
      thr_letter = letter;
      thr_word   = word;
   endtask

   // Reset thresholds: a press one tick under the dot limit, one at it, then the letter gap.
   task automatic test_default_timing();
      key_press(299);
      key_idle(2);
      key_press(300);
      key_idle(1001);
      settle();
   endtask

   task automatic test_letter_table();
      int unsigned len;
      int unsigned code;
      settle();
      load_timing(16'd2, 16'd4, 16'd9);
      for (len = 1; len <= 4; len++) begin
         for (code = 0; code < (32'd1 << len); code++) begin
            key_letter(len, 16'(code), (code % 3 == 0) ? 11 : 6);
         end
      end
      key_letter(5, 16'($urandom()), 6);
      key_letter(CODE_LEN_MAX, 16'hFFFF, 6);
      key_letter(CODE_LEN_MAX + 1, 16'h0000, 11);
      key_letter(CODE_LEN_MAX + 4, 16'($urandom()), 11);
      settle();
   endtask

   task automatic test_zero_gaps();
      settle();
      load_timing(16'd0, 16'd0, 16'd0);
      key_press(1);
      key_idle(1);
      key_press(3);
      key_idle(2);
      settle();
      load_timing(16'd1, 16'd1, 16'd1);
      key_press(1);
      key_idle(3);
      key_letter(2, 16'h0003, 2);
      settle();
      load_timing(16'd3, 16'd5, 16'd1);
      key_letter(2, 16'h0000, 7);
      key_letter(3, 16'h0002, 7);
      settle();
   endtask

   // Maximum dot limit: long presses still count as dots.
   task automatic test_long_presses();
      settle();
      sender_gaps = 1'b0;
      load_timing(16'hFFFF, 16'd20, 16'd30);
      key_press(60);
      key_idle(1);
      key_press(90);
      key_idle(35);
      settle();
      sender_gaps = 1'b1;
   endtask

   // The receiver holds off while dense results fill the decoder's event queue.
   task automatic test_backpressure();
      int unsigned i;
      settle();
      load_timing(16'd1, 16'd1, 16'd1);
      hold_request = 300;
      for (i = 0; i < 60; i++) begin
         key_press(1);
         key_idle(2);
      end
      settle();
   endtask

   task automatic test_random_traffic();
      int unsigned phase;
      int unsigned start;
      int unsigned len;
      int unsigned gap;
      int unsigned pick;
      for (phase = 0; phase < 5; phase++) begin
         settle();
         sender_gaps   = (phase < 4) && ($urandom_range(0, 3) != 0);
         receiver_gaps = (phase < 4) && ($urandom_range(0, 3) != 0);
         load_timing(16'($urandom_range(1, 6)), 16'($urandom_range(2, 12)),
                     16'($urandom_range(1, 30)));
         start = tick_count;
         while (tick_count - start < 60) begin
            if ($urandom_range(0, 9) == 0) begin
               repeat ($urandom_range(1, 12)) send_tick(1'($urandom_range(0, 1)));
            end else begin
               len  = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
               pick = $urandom_range(0, 3);
               if (pick == 0) begin
                  gap = symbol_gap();
               end else if (pick == 3) begin
                  gap = int'(thr_word) + $urandom_range(1, 4);
               end else begin
                  gap = int'(thr_letter) + $urandom_range(1, 3);
               end
               key_letter(len, 16'($urandom()), gap);
            end
         end
      end
   endtask

   initial begin
      clear_decoder_state();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_timing();
      test_letter_table();
      test_zero_gaps();
      test_long_presses();
      test_backpressure();
      test_random_traffic();
      settle();
      $display("tb_top: %0d key samples sent, %0d letters (%0d unknown) and %0d word ends checked",
               tick_count, letters_seen, unknown_seen, word_ends_seen);
      $display("tb_top: decoder held off its input on %0d cycles", held_off_cycles);
      if (fail_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

### morse_key_decoder.f
sv/mkd_pkg.sv
sv/mkd_front.sv
sv/mkd_queue.sv
sv/mkd_back.sv
sv/morse_key_decoder.sv
tb/tb_top.sv
